FILE: rtl/ifa_pkg.sv
// Shared types, codes and character tables for the integer to ASCII formatter.
// Used by ifa_dabble, ifa_digits and integer_to_ascii_formatter_unit.
// No dependencies.
`timescale 1ns / 1ps

package ifa_pkg;

  // Format selection codes.
  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_HEXL = 2'd1;
  localparam logic [1:0] MODE_HEXU = 2'd2;
  localparam logic [1:0] MODE_PTR  = 2'd3;

  // Digit counts of each format and the width of the decimal converter.
  localparam int DEC_DIGITS   = 10;
  localparam int HEX32_DIGITS = 8;
  localparam int PTR_DIGITS   = 16;
  localparam int DAB_BITS     = 32;
  localparam int BCD_W        = DEC_DIGITS * 4;
  localparam int CNT_W        = 5;
  localparam int DAB_CNT_W    = 6;

  // Input and result words.
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  mode;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE,
    ST_DIG
  } state_t;

  // Fixed text put before (or instead of) the digits.
  typedef enum logic [1:0] {
    PK_MINUS,
    PK_HEX,
    PK_NIL
  } pre_kind_t;

  // Control from the sequencer to the digit shifter.
  typedef struct packed {
    logic             load;
    logic             run;
    logic             upper;
    logic [CNT_W-1:0] cnt;
    logic [63:0]      data;
  } dig_ctrl_t;

  // Status from the digit shifter.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [6:0] ch;
  } dig_stat_t;

  // One digit nibble to its ASCII character.
  function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'b000, nib};
    end else if (upper) begin
      ch = 7'h37 + {3'b000, nib};
    end else begin
      ch = 7'h57 + {3'b000, nib};
    end
    return ch;
  endfunction

  // Character at position idx of a prefix text.
  function automatic logic [6:0] pre_char(input pre_kind_t kind, input logic [2:0] idx);
    logic [6:0] ch;
    case (kind)
      PK_MINUS: ch = 7'h2D;
      PK_HEX:   ch = (idx == 3'd0) ? 7'h30 : 7'h78;
      PK_NIL: begin
        case (idx)
          3'd0:    ch = 7'h28;
          3'd1:    ch = 7'h6E;
          3'd2:    ch = 7'h69;
          3'd3:    ch = 7'h6C;
          default: ch = 7'h29;
        endcase
      end
      default:  ch = 7'h2D;
    endcase
    return ch;
  endfunction

  // Index of the final character of a prefix text.
  function automatic logic [2:0] pre_last(input pre_kind_t kind);
    logic [2:0] idx;
    case (kind)
      PK_MINUS: idx = 3'd0;
      PK_HEX:   idx = 3'd1;
      PK_NIL:   idx = 3'd4;
      default:  idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: sequencer, prefix text and result register.
// Depends on ifa_pkg, ifa_dabble and ifa_digits.
`timescale 1ns / 1ps

// Usage:
// Drive in_word (value and mode) and raise start; the word is taken at a clock
// edge where start is high and busy is low. busy stays high until the last
// character of that word has been produced.
// Each character leaves on out_word for exactly one cycle with out_valid high;
// out_word.last marks the final character of the word. The receiver cannot
// stall the block, so every character must be taken when out_valid is high.
// In the pointer and nil cases the first character is registered from the prefix
// state entered at the accepting edge. Hex words go straight to 8 digit slots
// (leading zeros are skipped in slots that send nothing), pointers send 0x and 16
// digit slots, nil sends (nil). Decimal words first run the bit-serial BCD
// converter, then a minus sign if any, then 10 digit slots. The converter loop sets
// the decimal rate, the digit shift register sets the hex rate at one digit a cycle.
// Reset (rst_n low, synchronous) returns the block to idle and drops out_valid.

module integer_to_ascii_formatter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ifa_pkg::in_word_t  in_word,
  output logic               out_valid,
  output ifa_pkg::out_word_t out_word
);

  ifa_pkg::state_t    state_r, state_nxt;
  ifa_pkg::pre_kind_t pre_kind_r, pre_kind_nxt;
  logic [2:0]         pre_idx_r, pre_idx_nxt;
  logic               neg_r, neg_nxt;
  logic               upper_r, upper_nxt;
  logic               out_valid_r, out_valid_nxt;
  ifa_pkg::out_word_t out_word_r, out_word_nxt;

  ifa_pkg::dig_ctrl_t dig_ctrl;
  ifa_pkg::dig_stat_t dig_stat;
  logic                           dab_start;
  logic [ifa_pkg::DAB_BITS-1:0]   dab_mag;
  logic [ifa_pkg::BCD_W-1:0]      dab_bcd;
  logic                           dab_done;
  logic [31:0]                    low;
  logic                           accept;

  assign low     = in_word.value[31:0];
  assign accept  = start && (state_r == ifa_pkg::ST_IDLE);
  assign dab_mag = low[31] ? (~low + 32'd1) : low;

  ifa_dabble u_dab (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .mag   (dab_mag),
    .bcd   (dab_bcd),
    .done  (dab_done)
  );

  ifa_digits u_dig (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dig_ctrl),
    .stat  (dig_stat)
  );

  // Next state and sequencer registers.
  always_comb begin
    state_nxt    = state_r;
    pre_kind_nxt = pre_kind_r;
    pre_idx_nxt  = pre_idx_r;
    neg_nxt      = neg_r;
    upper_nxt    = upper_r;
    case (state_r)
      ifa_pkg::ST_IDLE: begin
        if (accept) begin
          pre_idx_nxt = 3'd0;
          upper_nxt   = (in_word.mode == ifa_pkg::MODE_HEXU);
          case (in_word.mode)
            ifa_pkg::MODE_DEC: begin
              neg_nxt      = low[31];
              pre_kind_nxt = ifa_pkg::PK_MINUS;
              state_nxt    = ifa_pkg::ST_CONV;
            end
            ifa_pkg::MODE_HEXL, ifa_pkg::MODE_HEXU: begin
              state_nxt = ifa_pkg::ST_DIG;
            end
            default: begin
              pre_kind_nxt = (in_word.value == 64'd0) ? ifa_pkg::PK_NIL : ifa_pkg::PK_HEX;
              state_nxt    = ifa_pkg::ST_PRE;
            end
          endcase
        end
      end
      ifa_pkg::ST_CONV: begin
        if (dab_done) begin
          state_nxt = neg_r ? ifa_pkg::ST_PRE : ifa_pkg::ST_DIG;
        end
      end
      ifa_pkg::ST_PRE: begin
        pre_idx_nxt = pre_idx_r + 3'd1;
        if (pre_idx_r == ifa_pkg::pre_last(pre_kind_r)) begin
          state_nxt = (pre_kind_r == ifa_pkg::PK_NIL) ? ifa_pkg::ST_IDLE : ifa_pkg::ST_DIG;
        end
      end
      ifa_pkg::ST_DIG: begin
        if (dig_stat.emit && dig_stat.last) begin
          state_nxt = ifa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ifa_pkg::ST_IDLE;
    endcase
  end

  // Outputs of each state: unit control and the next result word.
  always_comb begin
    dab_start      = 1'b0;
    dig_ctrl       = '0;
    dig_ctrl.upper = upper_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = '0;
    case (state_r)
      ifa_pkg::ST_IDLE: begin
        dig_ctrl.upper = (in_word.mode == ifa_pkg::MODE_HEXU);
        if (start) begin
          case (in_word.mode)
            ifa_pkg::MODE_DEC: begin
              dab_start = 1'b1;
            end
            ifa_pkg::MODE_HEXL, ifa_pkg::MODE_HEXU: begin
              dig_ctrl.load = 1'b1;
              dig_ctrl.cnt  = ifa_pkg::CNT_W'(ifa_pkg::HEX32_DIGITS);
              dig_ctrl.data = {low, 32'd0};
            end
            default: begin
              dig_ctrl.load = (in_word.value != 64'd0);
              dig_ctrl.cnt  = ifa_pkg::CNT_W'(ifa_pkg::PTR_DIGITS);
              dig_ctrl.data = in_word.value;
            end
          endcase
        end
      end
      ifa_pkg::ST_CONV: begin
        if (dab_done) begin
          dig_ctrl.load = 1'b1;
          dig_ctrl.cnt  = ifa_pkg::CNT_W'(ifa_pkg::DEC_DIGITS);
          dig_ctrl.data = {dab_bcd, {(64 - ifa_pkg::BCD_W){1'b0}}};
        end
      end
      ifa_pkg::ST_PRE: begin
        out_valid_nxt         = 1'b1;
        out_word_nxt.char_out = ifa_pkg::pre_char(pre_kind_r, pre_idx_r);
        out_word_nxt.last     = (pre_kind_r == ifa_pkg::PK_NIL) &&
                                (pre_idx_r == ifa_pkg::pre_last(pre_kind_r));
      end
      ifa_pkg::ST_DIG: begin
        dig_ctrl.run          = 1'b1;
        out_valid_nxt         = dig_stat.emit;
        out_word_nxt.char_out = dig_stat.ch;
        out_word_nxt.last     = dig_stat.last;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifa_pkg::ST_IDLE;
      pre_kind_r  <= ifa_pkg::PK_MINUS;
      pre_idx_r   <= 3'd0;
      neg_r       <= 1'b0;
      upper_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pre_kind_r  <= pre_kind_nxt;
      pre_idx_r   <= pre_idx_nxt;
      neg_r       <= neg_nxt;
      upper_r     <= upper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ifa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  // The final character of a word coincides with the return to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |-> !busy)
    else $error("still busy after the final character");

  // A character that is not the final one leaves while the word is in progress.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |-> busy)
    else $error("character left with no word in progress");

  // The decimal converter only finishes while the sequencer waits for it.
  a_dab_done: assert property (@(posedge clk) disable iff (!rst_n)
    dab_done |-> (state_r == ifa_pkg::ST_CONV))
    else $error("converter finished outside the conversion state");
`endif

endmodule

FILE: rtl/ifa_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on ifa_pkg.
`timescale 1ns / 1ps

module ifa_dabble (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ifa_pkg::DAB_BITS-1:0] mag,
  output logic [ifa_pkg::BCD_W-1:0]  bcd,
  output logic                       done
);

  logic [ifa_pkg::DAB_BITS-1:0]  bin_r, bin_nxt;
  logic [ifa_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [ifa_pkg::DAB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [ifa_pkg::BCD_W-1:0]     adj;

  // Add 3 to every BCD digit of 5 or more, then shift in the next binary bit.
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < ifa_pkg::DEC_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
  end

  // Load on start, otherwise step while bits remain.
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = ifa_pkg::DAB_CNT_W'(ifa_pkg::DAB_BITS);
    end else if (cnt_r != '0) begin
      bin_nxt  = {bin_r[ifa_pkg::DAB_BITS-2:0], 1'b0};
      bcd_nxt  = {adj[ifa_pkg::BCD_W-2:0], bin_r[ifa_pkg::DAB_BITS-1]};
      cnt_nxt  = cnt_r - ifa_pkg::DAB_CNT_W'(1);
      done_nxt = (cnt_r == ifa_pkg::DAB_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd  = bcd_r;
  assign done = done_r;

endmodule

FILE: rtl/ifa_digits.sv
// Digit shift register: sends nibbles out most significant first, one per cycle
// while run is high, dropping leading zeros. Depends on ifa_pkg.
`timescale 1ns / 1ps

module ifa_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  ifa_pkg::dig_ctrl_t  ctrl,
  output ifa_pkg::dig_stat_t  stat
);

  logic [63:0]               data_r, data_nxt;
  logic [ifa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      started_r, started_nxt;
  logic                      upper_r, upper_nxt;
  logic [3:0]                nib;
  logic                      leading;

  // A zero ahead of the first nonzero digit is skipped, but never the final one.
  assign nib     = data_r[63:60];
  assign leading = !started_r && (nib == 4'd0) && (cnt_r > ifa_pkg::CNT_W'(1));

  always_comb begin
    stat.emit = ctrl.run && !leading;
    stat.last = (cnt_r == ifa_pkg::CNT_W'(1));
    stat.ch   = ifa_pkg::hex_char(nib, upper_r);
  end

  // Load a new number or shift one digit out.
  always_comb begin
    data_nxt    = data_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    upper_nxt   = upper_r;
    if (ctrl.load) begin
      data_nxt    = ctrl.data;
      cnt_nxt     = ctrl.cnt;
      started_nxt = 1'b0;
      upper_nxt   = ctrl.upper;
    end else if (ctrl.run && cnt_r != '0) begin
      data_nxt    = {data_r[59:0], 4'd0};
      cnt_nxt     = cnt_r - ifa_pkg::CNT_W'(1);
      started_nxt = started_r || !leading;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    upper_r <= upper_nxt;
  end

endmodule
